### sv/thsd_pkg.sv
// thsd_pkg: shared widths, constants, codes and types of the thermostat stepper drive
// no dependencies; compile first
`default_nettype none

package thsd_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned TempW    = 9;
  localparam int unsigned PeriodW  = 10;
  localparam int unsigned RunW     = 4;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CoilW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // floor(s * 0.48898) as (s * ceil(0.48898 * 2^32)) >> 32, exact for 10-bit s
  localparam int unsigned ScaleMulW  = 31;
  localparam int unsigned ScaleShift = 32;
  localparam int unsigned ProdW      = SampleW + ScaleMulW;
  localparam logic [ScaleMulW-1:0] ScaleMul = 31'd2100153109;

  localparam logic [PeriodW-1:0] PeriodRst    = 10'd20;
  localparam logic [TempW-1:0]   HotEnterRst  = 9'd35;
  localparam logic [TempW-1:0]   HotExitRst   = 9'd25;
  localparam logic [TempW-1:0]   ColdEnterRst = 9'd15;
  localparam logic [TempW-1:0]   ColdExitRst  = 9'd30;
  localparam logic [RunW-1:0]    RunCountRst  = 4'd12;
  localparam logic [TempW-1:0]   TempMax      = 9'd500;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HOT  = 2'd1,
    MODE_COLD = 2'd2
  } mode_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD     = 3'd0,
    CFG_HOT_ENTER  = 3'd1,
    CFG_HOT_EXIT   = 3'd2,
    CFG_COLD_ENTER = 3'd3,
    CFG_COLD_EXIT  = 3'd4,
    CFG_RUN_COUNT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [TempW-1:0]   hot_enter;
    logic [TempW-1:0]   hot_exit;
    logic [TempW-1:0]   cold_enter;
    logic [TempW-1:0]   cold_exit;
    logic [RunW-1:0]    run_count;
  } cfg_t;

  typedef struct packed {
    logic [CoilW-1:0] coil_hot;
    logic [CoilW-1:0] coil_cold;
    logic [TempW-1:0] temperature;
    mode_e            mode;
    logic             busy;
  } res_t;

  // half-step coil sequence
  function automatic logic [CoilW-1:0] half_step(input logic [PhaseW-1:0] phase);
    logic [CoilW-1:0] pat;
    unique case (phase)
      3'd0: pat = 4'h9;
      3'd1: pat = 4'h8;
      3'd2: pat = 4'hC;
      3'd3: pat = 4'h4;
      3'd4: pat = 4'h6;
      3'd5: pat = 4'h2;
      3'd6: pat = 4'h3;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### sv/thsd_if.sv
// thsd_in_if / thsd_out_if: valid-ready channels for items and results
// depends on thsd_pkg
`default_nettype none

interface thsd_in_if;
  import thsd_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [SampleW-1:0] adc_sample;
  modport source (output valid, opcode, adc_sample, input ready);
  modport sink   (input valid, opcode, adc_sample, output ready);
endinterface

interface thsd_out_if;
  import thsd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CoilW-1:0] coil_hot;
  logic [CoilW-1:0] coil_cold;
  logic [TempW-1:0] temperature;
  logic [1:0]       mode;
  logic             busy_res;
  modport source (output valid, coil_hot, coil_cold, temperature, mode, busy_res,
                  input ready);
  modport sink   (input valid, coil_hot, coil_cold, temperature, mode, busy_res,
                  output ready);
endinterface

`default_nettype wire

### sv/thsd_scale.sv
// thsd_scale: adc sample to whole degrees by a constant reciprocal multiply
// depends on thsd_pkg
`default_nettype none

module thsd_scale (
  input  logic [thsd_pkg::SampleW-1:0] sample_i,
  output logic [thsd_pkg::TempW-1:0]   temp_o
);
  import thsd_pkg::*;

  logic [ProdW-1:0] prod;

  assign prod   = ProdW'(sample_i) * ProdW'(ScaleMul);
  assign temp_o = prod[ScaleShift +: TempW];

endmodule

`default_nettype wire

### sv/thsd_core.sv
// thsd_core: hysteresis mode rule and half-step run sequencer state
// depends on thsd_pkg; res_o shows the state as it will be after this step
`default_nettype none

module thsd_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  thsd_pkg::op_e              opcode_i,
  input  logic [thsd_pkg::TempW-1:0] temp_i,
  input  thsd_pkg::cfg_t             cfg_i,
  output thsd_pkg::res_t             res_o
);
  import thsd_pkg::*;

  localparam logic [PhaseW-1:0] PhaseLast = '1;

  mode_e              mode_q, mode_d, mode_nx, drv_mode;
  logic [TempW-1:0]   temp_q, temp_d;
  logic [PhaseW-1:0]  phase_q, phase_d, drv_phase;
  logic [RunW-1:0]    rep_q, rep_d, rep_dec;
  logic [PeriodW-1:0] tick_q, tick_d, tick_inc, per;
  logic               run_q, run_d, drive;
  logic [CoilW-1:0]   hot_q, hot_d, cold_q, cold_d;

  always_comb begin
    mode_nx = mode_q;
    priority if (mode_q == MODE_IDLE && temp_i > cfg_i.hot_enter) begin
      mode_nx = MODE_HOT;
    end else if (temp_i < cfg_i.cold_enter) begin
      mode_nx = MODE_COLD;
    end else if (mode_q == MODE_COLD && temp_i > cfg_i.cold_exit) begin
      mode_nx = MODE_IDLE;
    end else if (mode_q == MODE_HOT && temp_i < cfg_i.hot_exit) begin
      mode_nx = MODE_IDLE;
    end else begin
      mode_nx = mode_q;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    temp_d    = temp_q;
    phase_d   = phase_q;
    rep_d     = rep_q;
    tick_d    = tick_q;
    run_d     = run_q;
    hot_d     = hot_q;
    cold_d    = cold_q;
    drive     = 1'b0;
    drv_mode  = mode_q;
    drv_phase = '0;
    per       = (cfg_i.period == '0) ? PeriodW'(1) : cfg_i.period;
    tick_inc  = tick_q + 1'b1;
    rep_dec   = rep_q - 1'b1;

    if (step_i) begin
      unique case (opcode_i)
        OP_SAMPLE: begin
          // samples are ignored while a run is busy
          if (!run_q) begin
            temp_d = temp_i;
            mode_d = mode_nx;
            if ((mode_nx == MODE_HOT || mode_nx == MODE_COLD) && cfg_i.run_count != '0) begin
              run_d    = 1'b1;
              phase_d  = '0;
              tick_d   = '0;
              rep_d    = cfg_i.run_count;
              drive    = 1'b1;
              drv_mode = mode_nx;
            end
          end
        end
        OP_TICK: begin
          if (run_q) begin
            if (tick_inc < per) begin
              tick_d = tick_inc;
            end else begin
              tick_d = '0;
              if (phase_q == PhaseLast) begin
                phase_d = '0;
                rep_d   = rep_dec;
                if (rep_dec == '0) begin
                  run_d = 1'b0;
                end else begin
                  drive = 1'b1;
                end
              end else begin
                phase_d   = phase_q + 1'b1;
                drv_phase = phase_q + 1'b1;
                drive     = 1'b1;
              end
            end
          end
        end
      endcase
    end

    if (drive) begin
      if (drv_mode == MODE_HOT) begin
        hot_d = half_step(drv_phase);
      end else if (drv_mode == MODE_COLD) begin
        cold_d = half_step(drv_phase);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      temp_q  <= '0;
      phase_q <= '0;
      rep_q   <= '0;
      tick_q  <= '0;
      run_q   <= 1'b0;
      hot_q   <= '0;
      cold_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      temp_q  <= temp_d;
      phase_q <= phase_d;
      rep_q   <= rep_d;
      tick_q  <= tick_d;
      run_q   <= run_d;
      hot_q   <= hot_d;
      cold_q  <= cold_d;
    end
  end

  always_comb begin
    res_o.coil_hot    = hot_d;
    res_o.coil_cold   = cold_d;
    res_o.temperature = temp_d;
    res_o.mode        = mode_d;
    res_o.busy        = run_d;
  end

endmodule

`default_nettype wire

### sv/thermostat_stepper_drive.sv
// thermostat_stepper_drive: top level with config registers, input and result stages
// depends on thsd_pkg, thsd_if, thsd_scale, thsd_core
//
// Usage:
//   in_i carries items: opcode 0 is an adc sample, opcode 1 a one millisecond
//   tick. out_o returns one result per item: both coil patterns, the last
//   temperature, the mode and the run busy flag, as they stand after the item.
//   Items are registered on transfer; from the input stage the sample is scaled
//   with a single constant multiply, the mode rule and sequencer step are applied
//   and the result register is loaded. One item per cycle is taken at a sustained
//   rate while the receiver accepts every result. When the receiver stalls, the
//   result register holds and one more item waits in the input stage; in_i.ready
//   drops only when both are full. Config writes (cfg_we_i, cfg_idx_i,
//   cfg_wdata_i) take effect at the next edge; the user makes them only while no
//   item is in flight, which the block does not enforce. Unknown indices are
//   ignored. Reset loads the default thresholds, period 20 and run count 12, clears
//   mode, temperature, coils and run state, and empties both stages.
`default_nettype none

module thermostat_stepper_drive (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [thsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [thsd_pkg::CfgDataW-1:0] cfg_wdata_i,
  thsd_in_if.sink                       in_i,
  thsd_out_if.source                    out_o
);
  import thsd_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic               s1_vld_q, s1_vld_d;
  op_e                s1_op_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               out_vld_q, out_vld_d;
  res_t               out_res_q, core_res;
  logic [TempW-1:0]   temp;
  logic               adv, step, in_xfer;

  // config registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERIOD:     cfg_d.period     = cfg_wdata_i;
        CFG_HOT_ENTER:  cfg_d.hot_enter  = cfg_wdata_i[TempW-1:0];
        CFG_HOT_EXIT:   cfg_d.hot_exit   = cfg_wdata_i[TempW-1:0];
        CFG_COLD_ENTER: cfg_d.cold_enter = cfg_wdata_i[TempW-1:0];
        CFG_COLD_EXIT:  cfg_d.cold_exit  = cfg_wdata_i[TempW-1:0];
        CFG_RUN_COUNT:  cfg_d.run_count  = cfg_wdata_i[RunW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period     <= PeriodRst;
      cfg_q.hot_enter  <= HotEnterRst;
      cfg_q.hot_exit   <= HotExitRst;
      cfg_q.cold_enter <= ColdEnterRst;
      cfg_q.cold_exit  <= ColdExitRst;
      cfg_q.run_count  <= RunCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control
  assign adv        = !out_vld_q || out_o.ready;
  assign step       = s1_vld_q && adv;
  assign in_i.ready = !s1_vld_q || adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_xfer) begin
      s1_vld_d = 1'b1;
    end else if (adv) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = adv ? s1_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q     <= op_e'(in_i.opcode);
      s1_sample_q <= in_i.adc_sample;
    end
    if (step) begin
      out_res_q <= core_res;
    end
  end

  thsd_scale u_scale (
    .sample_i (s1_sample_q),
    .temp_o   (temp)
  );

  thsd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .opcode_i (s1_op_q),
    .temp_i   (temp),
    .cfg_i    (cfg_q),
    .res_o    (core_res)
  );

  assign out_o.valid       = out_vld_q;
  assign out_o.coil_hot    = out_res_q.coil_hot;
  assign out_o.coil_cold   = out_res_q.coil_cold;
  assign out_o.temperature = out_res_q.temperature;
  assign out_o.mode        = out_res_q.mode;
  assign out_o.busy_res    = out_res_q.busy;

`ifndef ASSERT_OFF
  // a busy run always belongs to the hot or cold motor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.busy |-> out_res_q.mode != MODE_IDLE)
    else $error("busy result in idle mode");

  // scaled temperature never exceeds the full-scale reading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_res_q.temperature <= TempMax)
    else $error("temperature out of range");

  // an empty result stage never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_i.ready)
    else $error("input stalled with empty result stage");

  // a held item moves into an empty result stage on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !out_vld_q |=> out_vld_q)
    else $error("held item not delivered");
`endif

endmodule

`default_nettype wire

### bench/thermostat_stepper_drive_test.sv
// self-checking bench for thermostat_stepper_drive: scaled samples, mode rule, half-step runs
// drives both channels at random rates and checks every result against its own predictor
// depends on thsd_pkg, thsd_if and the thermostat_stepper_drive rtl
`timescale 1ns / 100ps

module thermostat_stepper_drive_test;
  import thsd_pkg::*;

  // half-step coil patterns, phase 0 in the low nibble
  localparam logic [8*CoilW-1:0] CoilSeq = 32'h1326_4C89;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;
  localparam int unsigned SettleCycles = 4;

  typedef enum logic [1:0] {
    IDLE_NONE = 2'd0,
    IDLE_SEND = 2'd1,
    IDLE_RECV = 2'd2,
    IDLE_BOTH = 2'd3
  } idle_mode_e;

  typedef struct packed {
    op_e                op;
    logic [SampleW-1:0] sample;
  } reading_t;

  typedef struct packed {
    mode_e              mode;
    logic [TempW-1:0]   temp;
    logic [PhaseW-1:0]  phase;
    logic [RunW-1:0]    reps_left;
    logic [PeriodW-1:0] ticks;
    logic               running;
    logic [CoilW-1:0]   hot_coils;
    logic [CoilW-1:0]   cold_coils;
  } drive_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  thsd_in_if  reading_bus ();
  thsd_out_if status_bus ();

  thermostat_stepper_drive DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (reading_bus),
    .out_o       (status_bus)
  );

  cfg_t         drive_cfg;
  drive_state_t staged_drive;   // runs ahead while readings are queued
  drive_state_t tracked_drive;  // advances on each input transfer
  reading_t     pending_readings[$];
  res_t         predicted_status[$];
  reading_t     next_reading;
  res_t         due_status;
  logic         reading_taken = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_left = 0;
  int unsigned  mismatches = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic drive_state_t show_phase(drive_state_t st);
    logic [CoilW-1:0] pat;
    pat = CoilSeq[st.phase*CoilW +: CoilW];
    if (st.mode == MODE_HOT) begin
      st.hot_coils = pat;
    end else if (st.mode == MODE_COLD) begin
      st.cold_coils = pat;
    end
    return st;
  endfunction

  function automatic drive_state_t advance_drive(drive_state_t st, cfg_t cfg, op_e op,
                                                 logic [SampleW-1:0] sample);
    drive_state_t nx;
    int unsigned  deg;
    int unsigned  per;
    nx = st;
    if (op == OP_SAMPLE) begin
      if (!st.running) begin
        deg = sample;
        deg = deg * 48898 / 100000;
        nx.temp = deg[TempW-1:0];
        if (nx.mode == MODE_IDLE && nx.temp > cfg.hot_enter) begin
          nx.mode = MODE_HOT;
        end else if (nx.temp < cfg.cold_enter) begin
          nx.mode = MODE_COLD;
        end else if (nx.mode == MODE_COLD && nx.temp > cfg.cold_exit) begin
          nx.mode = MODE_IDLE;
        end else if (nx.mode == MODE_HOT && nx.temp < cfg.hot_exit) begin
          nx.mode = MODE_IDLE;
        end
        if (nx.mode != MODE_IDLE && cfg.run_count != '0) begin
          nx.running   = 1'b1;
          nx.phase     = '0;
          nx.ticks     = '0;
          nx.reps_left = cfg.run_count;
          nx = show_phase(nx);
        end
      end
    end else if (st.running) begin
      per = (cfg.period == '0) ? 1 : cfg.period;
      nx.ticks = st.ticks + 1'b1;
      if (nx.ticks >= per) begin
        nx.ticks = '0;
        if (st.phase == 3'd7) begin
          nx.phase     = '0;
          nx.reps_left = st.reps_left - 1'b1;
          if (nx.reps_left == '0) begin
            nx.running = 1'b0;
          end
        end else begin
          nx.phase = st.phase + 1'b1;
        end
        // a finished run leaves the last pattern on the coils
        if (nx.running) begin
          nx = show_phase(nx);
        end
      end
    end
    return nx;
  endfunction

  function automatic res_t status_of(drive_state_t st);
    res_t r;
    r.coil_hot    = st.hot_coils;
    r.coil_cold   = st.cold_coils;
    r.temperature = st.temp;
    r.mode        = st.mode;
    r.busy        = st.running;
    return r;
  endfunction

  // mostly samples that land on or next to a threshold
  function automatic logic [SampleW-1:0] pick_sample(cfg_t cfg);
    int unsigned deg;
    int unsigned s;
    case ($urandom_range(4))
      0: deg = cfg.hot_enter;
      1: deg = cfg.hot_exit;
      2: deg = cfg.cold_enter;
      3: deg = cfg.cold_exit;
      default: deg = 1000;
    endcase
    if (deg == 1000) begin
      s = $urandom_range(1023);
    end else begin
      deg = deg + $urandom_range(4);
      deg = (deg < 2) ? 0 : deg - 2;
      if (deg > 500) deg = 500;
      s = (deg * 100000 + 48897) / 48898;
      if (s > 1023) s = 1023;
    end
    return s[SampleW-1:0];
  endfunction

  task automatic push_reading(input op_e op, input logic [SampleW-1:0] sample);
    reading_t r;
    r.op     = op;
    r.sample = sample;
    staged_drive = advance_drive(staged_drive, drive_cfg, op, sample);
    pending_readings.push_back(r);
  endtask

  // well-formed runs: samples while idle, ticks while stepping, a little noise
  task automatic queue_readings(input int unsigned count);
    int unsigned useful;
    op_e         op;
    useful = 0;
    while (useful < count) begin
      if (staged_drive.running) begin
        op = ($urandom_range(9) == 0) ? OP_SAMPLE : OP_TICK;
      end else begin
        op = ($urandom_range(9) < 8) ? OP_SAMPLE : OP_TICK;
      end
      // ignored readings are not counted
      if ((op == OP_TICK) == staged_drive.running) useful++;
      if (op == OP_SAMPLE) begin
        push_reading(op, pick_sample(drive_cfg));
      end else begin
        push_reading(op, SampleW'($urandom_range(1023)));
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value,
                           input int unsigned width);
    logic [CfgDataW-1:0] data;
    data = CfgDataW'($urandom_range(1023));
    for (int b = 0; b < width; b++) data[b] = value[b];
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PERIOD:     drive_cfg.period     = data;
      CFG_HOT_ENTER:  drive_cfg.hot_enter  = data[TempW-1:0];
      CFG_HOT_EXIT:   drive_cfg.hot_exit   = data[TempW-1:0];
      CFG_COLD_ENTER: drive_cfg.cold_enter = data[TempW-1:0];
      CFG_COLD_EXIT:  drive_cfg.cold_exit  = data[TempW-1:0];
      CFG_RUN_COUNT:  drive_cfg.run_count  = data[RunW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_bench();
    while (pending_readings.size() != 0 || reading_bus.valid ||
           predicted_status.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input idle_mode_e idling, input int unsigned hold,
                           input int unsigned period, input int unsigned he,
                           input int unsigned hx, input int unsigned ce,
                           input int unsigned cx, input int unsigned rc,
                           input int unsigned count);
    write_reg(CFG_PERIOD, period, PeriodW);
    write_reg(CFG_HOT_ENTER, he, TempW);
    write_reg(CFG_HOT_EXIT, hx, TempW);
    write_reg(CFG_COLD_ENTER, ce, TempW);
    write_reg(CFG_COLD_EXIT, cx, TempW);
    write_reg(CFG_RUN_COUNT, rc, RunW);
    // unmapped index, must not disturb anything
    write_reg($urandom_range(1) ? CfgIdxSpareHi : CfgIdxSpareLo, $urandom_range(1023),
              CfgDataW);
    case (idling)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 73; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default:   begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
    hold_left = hold;
    queue_readings(count);
    drain_bench();
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // sender: next reading goes out after the current one transfers
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      reading_bus.valid <= 1'b0;
    end else if (!reading_bus.valid || reading_taken) begin
      if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_reading = pending_readings.pop_front();
        reading_bus.valid      <= 1'b1;
        reading_bus.opcode     <= next_reading.op;
        reading_bus.adc_sample <= next_reading.sample;
      end else begin
        reading_bus.valid      <= 1'b0;
        reading_bus.opcode     <= 1'($urandom_range(1));
        reading_bus.adc_sample <= SampleW'($urandom_range(1023));
      end
    end
    reading_taken = 1'b0;
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      status_bus.ready <= 1'b0;
    end else begin
      status_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (reading_bus.valid && reading_bus.ready) begin
        tracked_drive = advance_drive(tracked_drive, drive_cfg, op_e'(reading_bus.opcode),
                                      reading_bus.adc_sample);
        predicted_status.push_back(status_of(tracked_drive));
        reading_taken = 1'b1;
      end
      if (status_bus.valid && status_bus.ready) begin
        if (predicted_status.size() == 0) begin
          $display("%0t: result transfer with no prediction pending, expected none, actual %h",
                   $time, {status_bus.coil_hot, status_bus.coil_cold,
                   status_bus.temperature, status_bus.mode, status_bus.busy_res});
          mismatches++;
        end else begin
          due_status = predicted_status.pop_front();
          check_field("coil_hot", due_status.coil_hot, status_bus.coil_hot);
          check_field("coil_cold", due_status.coil_cold, status_bus.coil_cold);
          check_field("temperature", due_status.temperature, status_bus.temperature);
          check_field("mode", due_status.mode, status_bus.mode);
          check_field("busy_res", due_status.busy, status_bus.busy_res);
        end
      end
    end
  end

  initial begin
    idle_mode_e  idling;
    int unsigned he;
    int unsigned ce;
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_wdata              = '0;
    reading_bus.valid      = 1'b0;
    reading_bus.opcode     = 1'b0;
    reading_bus.adc_sample = '0;
    status_bus.ready       = 1'b0;
    drive_cfg.period     = PeriodRst;
    drive_cfg.hot_enter  = HotEnterRst;
    drive_cfg.hot_exit   = HotExitRst;
    drive_cfg.cold_enter = ColdEnterRst;
    drive_cfg.cold_exit  = ColdExitRst;
    drive_cfg.run_count  = RunCountRst;
    staged_drive  = '0;
    tracked_drive = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: idle tick, full-scale sample starts a hot run,
    // samples during the run are dropped, one full default period of ticks
    push_reading(OP_TICK, 10'h3FF);
    push_reading(OP_SAMPLE, 10'h3FF);
    push_reading(OP_SAMPLE, 10'h000);
    for (int i = 0; i < 20; i++) push_reading(OP_TICK, i[0] ? 10'h155 : 10'h2AA);
    drain_bench();

    run_phase(IDLE_NONE, 300, 1, 35, 25, 15, 30, 2, 160);
    run_phase(IDLE_SEND, 0, 0, 40, 30, 20, 35, 1, 160);
    run_phase(IDLE_RECV, 0, 2, 45, 28, 18, 33, 3, 160);
    run_phase(IDLE_BOTH, 0, 3, 0, 0, 0, 0, 3, 140);
    run_phase(IDLE_NONE, 0, 1, 511, 511, 511, 511, 1, 140);
    run_phase(IDLE_SEND, 0, 1, 100, 50, 20, 60, 0, 140);
    run_phase(IDLE_RECV, 0, 1023, 60, 40, 20, 50, 15, 60);
    run_phase(IDLE_BOTH, 0, 1, 200, 150, 50, 100, 15, 160);
    for (int k = 0; k < 4; k++) begin
      idling = idle_mode_e'(k);
      he = $urandom_range(300, 20);
      ce = $urandom_range(he, 0);
      run_phase(idling, 0, $urandom_range(4, 1), he, $urandom_range(he, 0), ce,
                $urandom_range(350, ce), $urandom_range(15), 120);
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
